// ===== hdl/point_to_arc_distance_core_assert.svh =====
// ----------------------------------------------------------------------------
// point_to_arc_distance_core assertion macros
// Short forms for the concurrent checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_ARC_DISTANCE_CORE_ASSERT_SVH
`define POINT_TO_ARC_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define PTAD_ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ptad check failed");

// next-cycle implication
`define PTAD_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ptad check failed");

`endif

// ===== hdl/ptad_pkg.sv =====
// ----------------------------------------------------------------------------
// ptad_pkg
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package ptad_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int CORDIC_STEPS = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
  // squares, sum, one root bit per stage for 33 bits
  localparam int LEN_LAT = 35;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_START_X     = 3'd2,
    REG_START_Y     = 3'd3,
    REG_END_X       = 3'd4,
    REG_END_Y       = 3'd5,
    REG_START_ANGLE = 3'd6,
    REG_END_ANGLE   = 3'd7
  } reg_idx_t;

  // atan(2^-i) as a 32-bit turn fraction
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ptad_if.sv =====
// ----------------------------------------------------------------------------
// ptad stream interfaces
// Query point channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptad_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic        [31:0] tolerance;
  modport source (output valid, point_x, point_y, tolerance, input ready);
  modport sink   (input valid, point_x, point_y, tolerance, output ready);
endinterface

interface ptad_out_if;
  logic        valid;
  logic        ready;
  logic [32:0] distance;
  logic        is_near;
  modport source (output valid, distance, is_near, input ready);
  modport sink   (input valid, distance, is_near, output ready);
endinterface
`default_nettype wire

// ===== hdl/point_to_arc_distance_core.sv =====
// ----------------------------------------------------------------------------
// point_to_arc_distance_core
// Distance from a query point to a configured circular arc, with near flag.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | handshake
//  in_ch    | in  | point_x, point_y, tolerance    | valid/ready
//  out_ch   | out | distance, is_near              | valid/ready
//  apb      | in  | center, start, end, angles     | psel/penable, pready=1
//
// One item per cycle while the output is not stalled. 39 register stages:
// input register, differences, 35 stages of the length units (squares, sum,
// then one root bit per stage) with the CORDIC beside them, compare stage,
// output register.
// Synchronous active-high reset clears all valid bits and the config registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module point_to_arc_distance_core import ptad_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  ptad_in_if.sink          in_ch,
  ptad_out_if.source       out_ch
);

  // ---------------- configuration ----------------
  logic signed [31:0] center_x, center_y, start_x, start_y, end_x, end_y;
  logic        [15:0] start_angle, end_angle;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0; center_y <= '0; start_x <= '0; start_y <= '0;
      end_x <= '0; end_y <= '0; start_angle <= '0; end_angle <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_CENTER_X:    center_x    <= pwdata;
        REG_CENTER_Y:    center_y    <= pwdata;
        REG_START_X:     start_x     <= pwdata;
        REG_START_Y:     start_y     <= pwdata;
        REG_END_X:       end_x       <= pwdata;
        REG_END_Y:       end_y       <= pwdata;
        REG_START_ANGLE: start_angle <= pwdata[15:0];
        REG_END_ANGLE:   end_angle   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X:    prdata = center_x;
      REG_CENTER_Y:    prdata = center_y;
      REG_START_X:     prdata = start_x;
      REG_START_Y:     prdata = start_y;
      REG_END_X:       prdata = end_x;
      REG_END_Y:       prdata = end_y;
      REG_START_ANGLE: prdata = {16'h0, start_angle};
      REG_END_ANGLE:   prdata = {16'h0, end_angle};
      default:         prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic               v0, v1, pv;
  logic               vdly [0:LEN_LAT-1];
  logic signed [31:0] px, py;
  logic        [31:0] tol0, tol1;
  logic        [31:0] tdly [0:LEN_LAT-1];

  logic signed [32:0] dcx, dcy, rsx, rsy, rex, rey, d1x, d1y, d2x, d2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      pv <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int j = 0; j < LEN_LAT; j++) vdly[j] <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
      v1 <= v0;
      vdly[0] <= v1;
      for (int j = 1; j < LEN_LAT; j++) vdly[j] <= vdly[j-1];
      pv <= vdly[LEN_LAT-1];
      out_ch.valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= in_ch.point_x;
      py   <= in_ch.point_y;
      tol0 <= in_ch.tolerance;
      tol1 <= tol0;
      dcx <= 33'(px) - 33'(center_x);
      dcy <= 33'(py) - 33'(center_y);
      rsx <= 33'(start_x) - 33'(center_x);
      rsy <= 33'(start_y) - 33'(center_y);
      rex <= 33'(end_x) - 33'(center_x);
      rey <= 33'(end_y) - 33'(center_y);
      d1x <= 33'(px) - 33'(start_x);
      d1y <= 33'(py) - 33'(start_y);
      d2x <= 33'(px) - 33'(end_x);
      d2y <= 33'(py) - 33'(end_y);
      tdly[0] <= tol1;
      for (int j = 1; j < LEN_LAT; j++) tdly[j] <= tdly[j-1];
    end
  end

  logic [32:0] dc, rs, re, d1, d2;
  logic [31:0] acc;
  logic        zro;

  ptad_length u_len_dc (.clk, .en, .dx(dcx), .dy(dcy), .len(dc));
  ptad_length u_len_rs (.clk, .en, .dx(rsx), .dy(rsy), .len(rs));
  ptad_length u_len_re (.clk, .en, .dx(rex), .dy(rey), .len(re));
  ptad_length u_len_d1 (.clk, .en, .dx(d1x), .dy(d1y), .len(d1));
  ptad_length u_len_d2 (.clk, .en, .dx(d2x), .dy(d2y), .len(d2));
  ptad_cordic u_cordic (.clk, .en, .dx(dcx), .dy(dcy), .acc_out(acc), .zero_out(zro));

  // ---------------- compare stage ----------------
  logic [31:0] acc_rnd;
  logic [15:0] ang;
  logic        in_sweep;
  assign acc_rnd = acc + 32'h0000_8000;
  assign ang     = zro ? 16'h0 : acc_rnd[31:16];
  // wrapped sweep when start lies past end
  assign in_sweep = (start_angle > end_angle)
                  ? (ang >= start_angle || ang <= end_angle)
                  : (ang >= start_angle && ang <= end_angle);

  logic        p_inside;
  logic [32:0] p_din, p_dmin, p_dev;
  logic [31:0] p_tol;
  logic [32:0] dist_sel;

  always_ff @(posedge clk) begin
    if (en) begin
      p_inside <= in_sweep;
      p_din    <= (dc >= rs) ? dc - rs : rs - dc;
      p_dmin   <= (d1 < d2) ? d1 : d2;
      p_dev    <= (dc >= re) ? dc - re : re - dc;
      p_tol    <= tdly[LEN_LAT-1];
    end
  end

  assign dist_sel = p_inside ? p_din : p_dmin;

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.distance <= dist_sel;
      out_ch.is_near  <= (p_dev <= {1'b0, p_tol}) && (dist_sel < {1'b0, p_tol});
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptad_length.sv =====
// ----------------------------------------------------------------------------
// ptad_length
// Pipelined Euclidean length: squares, sum, then one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module ptad_length import ptad_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] dx,
  input  wire logic signed [32:0] dy,
  output logic             [32:0] len
);

  logic [31:0] ax, ay;
  logic [63:0] sqx, sqy;
  logic [64:0] sum;

  // differences of two 32-bit values never reach -2^32, so |d| fits 32 bits
  assign ax = 32'(dx[32] ? -dx : dx);
  assign ay = 32'(dy[32] ? -dy : dy);

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= 64'(ax) * 64'(ax);
      sqy <= 64'(ay) * 64'(ay);
      sum <= 65'(sqx) + 65'(sqy);
    end
  end

  logic [65:0] rad  [0:33];
  logic [33:0] rem  [0:33];
  logic [32:0] root [0:33];

  assign rad[0]  = {1'b0, sum};
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < 33; k++) begin : g_bit
    logic [35:0] rt, tr;
    logic        ge;
    assign rt = {rem[k], rad[k][65:64]};
    assign tr = {1'b0, root[k], 2'b01};
    assign ge = (rt >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= {rad[k][63:0], 2'b00};
        rem[k+1]  <= ge ? 34'(rt - tr) : rt[33:0];
        root[k+1] <= {root[k][31:0], ge};
      end
    end
  end

  assign len = root[33];

endmodule
`default_nettype wire

// ===== hdl/ptad_cordic.sv =====
// ----------------------------------------------------------------------------
// ptad_cordic
// Pipelined vectoring CORDIC giving the turn fraction of (x, y).
// ----------------------------------------------------------------------------
`default_nettype none
module ptad_cordic import ptad_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] dx,
  input  wire logic signed [32:0] dy,
  output logic             [31:0] acc_out,
  output logic                    zero_out
);

  logic signed [35:0] xs  [1:LEN_LAT];
  logic signed [35:0] ys  [1:LEN_LAT];
  logic        [31:0] acc [1:LEN_LAT];
  logic               zro [1:LEN_LAT];

  logic signed [35:0] xe, ye;
  assign xe = 36'(dx);
  assign ye = 36'(dy);

  // left half plane: rotate by a half turn first
  always_ff @(posedge clk) begin
    if (en) begin
      xs[1]  <= dx[32] ? -xe : xe;
      ys[1]  <= dx[32] ? -ye : ye;
      acc[1] <= dx[32] ? 32'h8000_0000 : 32'h0;
      zro[1] <= (dx == '0) && (dy == '0);
    end
  end

  for (genvar k = 1; k < LEN_LAT; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zro[k+1] <= zro[k];
        if (k - 1 < CORDIC_STEPS) begin
          if (ys[k] > 0) begin
            xs[k+1]  <= xs[k] + (ys[k] >>> (k - 1));
            ys[k+1]  <= ys[k] - (xs[k] >>> (k - 1));
            acc[k+1] <= acc[k] + atan_turns(5'(k - 1));
          end else begin
            xs[k+1]  <= xs[k] - (ys[k] >>> (k - 1));
            ys[k+1]  <= ys[k] + (xs[k] >>> (k - 1));
            acc[k+1] <= acc[k] - atan_turns(5'(k - 1));
          end
        end else begin
          xs[k+1]  <= xs[k];
          ys[k+1]  <= ys[k];
          acc[k+1] <= acc[k];
        end
      end
    end
  end

  assign acc_out  = acc[LEN_LAT];
  assign zero_out = zro[LEN_LAT];

endmodule
`default_nettype wire

// ===== hdl/ptad_checker.sv =====
// ----------------------------------------------------------------------------
// ptad_checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_to_arc_distance_core_assert.svh"
module ptad_checker import ptad_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [32:0] distance,
  input wire logic        is_near
);

  // a stalled result stays and holds its payload
  `PTAD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PTAD_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready,
                    $stable(distance) && $stable(is_near))
  // an empty output register never blocks the input
  `PTAD_ASSERT_NOW(a_in_free, clk, rst, !out_valid, in_ready)
  // near implies distance below a 32-bit tolerance
  `PTAD_ASSERT_NOW(a_near_range, clk, rst, out_valid && is_near, !distance[32])

endmodule

bind point_to_arc_distance_core ptad_checker u_ptad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .distance  (out_ch.distance),
  .is_near   (out_ch.is_near)
);
`default_nettype wire
